>>> design/assert_macros.svh
// assertion macros for the ground contact detector
// included by the top level, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GCD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GCD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define GCD_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> design/gcd_pkg.sv
// shared types and constants for the ground contact detector
// no dependencies
package gcd_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 23;
    localparam logic [CfgIdxW-1:0] CfgMass = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgThrX = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgThrY = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgThrZ = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgFilt = 3'd4;
    localparam logic [1:0] ActTick = 2'd0;
    localparam logic [1:0] ActStart = 2'd1;
    localparam logic [1:0] ActStop = 2'd2;
    localparam logic [1:0] ModeOff = 2'd0;
    localparam logic [1:0] ModeUnknown = 2'd1;
    localparam logic [1:0] ModeGround = 2'd2;
    localparam logic [1:0] ModeFlying = 2'd3;
    localparam logic [11:0] GravityQ8 = 12'd2511;
    localparam int unsigned QDepth = 2;

    typedef struct packed {
        logic [1:0] action;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [23:0] cmd_force_x;
        logic signed [23:0] cmd_force_y;
        logic signed [23:0] cmd_force_z;
        logic imu_valid;
    } t_in_item;

    typedef struct packed {
        logic [1:0] contact_state;
        logic [15:0] debounce_count;
    } t_out_item;

    // front-end classification passed to the back end
    typedef struct packed {
        logic need_eval;
        logic [1:0] action;
        t_in_item item;
    } t_job;

    typedef enum logic [1:0] {
        t_st_idle,
        t_st_calc,
        t_st_out
    } t_state;
endpackage

>>> design/gcd_stream_if.sv
// valid/ready channel carrying one item
// no dependencies
interface gcd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/gcd_front.sv
// front end: accepts items, classifies them, holds a short queue
// depends on gcd_pkg, gcd_stream_if
module gcd_front (
    input  logic i_clk,
    input  logic i_rst_n,
    gcd_stream_if.sink s_in,
    output gcd_pkg::t_job o_job,
    output logic o_job_valid,
    input  logic i_job_pop
);
    gcd_pkg::t_job r_q [gcd_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    gcd_pkg::t_job n_job;
    logic push;

    assign s_in.ready = (r_cnt != 2'd2);
    assign push = s_in.valid && s_in.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];

    always_comb begin
        n_job.item = s_in.data;
        n_job.action = s_in.data.action;
        n_job.need_eval = (s_in.data.action == gcd_pkg::ActTick);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_job_pop};
        end
    end
endmodule

>>> design/gcd_back.sv
// back end: force rotation on a shared multiplier, contact state machine
// depends on gcd_pkg, gcd_stream_if
module gcd_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  gcd_pkg::t_job i_job,
    input  logic i_job_valid,
    output logic o_job_pop,
    input  logic [15:0] i_mass,
    input  logic [22:0] i_thr_x,
    input  logic [22:0] i_thr_y,
    input  logic [22:0] i_thr_z,
    input  logic [15:0] i_filt,
    gcd_stream_if.source s_out,
    output logic [1:0] o_mode
);
    gcd_pkg::t_state r_state, n_state;
    logic [4:0] r_step;
    logic [1:0] r_mode;
    logic [15:0] r_ticks;
    // vector and products
    logic signed [25:0] r_v0, r_v1, r_v2;
    logic signed [34:0] r_s;
    logic signed [43:0] r_d, r_c0, r_c1, r_c2;
    logic signed [63:0] r_r0, r_r1, r_r2;
    logic signed [55:0] r_prod;
    logic signed [27:0] r_g;
    logic signed [43:0] ma;
    logic signed [25:0] mb;
    logic signed [69:0] mp_full;
    gcd_pkg::t_in_item it;
    logic r_ov;
    gcd_pkg::t_out_item r_out;
    logic signed [64:0] ax, ay, az, azg, gq;
    logic pass_x, pass_y, pass_zg, pass_za, gnd, air, pass;
    logic [16:0] inc;

    function automatic logic [1:0] n_mode_out(input logic [1:0] m, input gcd_pkg::t_job j,
            input logic g, input logic a, input logic p, input logic [16:0] c,
            input logic [15:0] f);
        logic [1:0] res;
        res = m;
        if (j.action == gcd_pkg::ActStart) res = gcd_pkg::ModeUnknown;
        else if (j.action == gcd_pkg::ActStop) res = gcd_pkg::ModeOff;
        else if (j.need_eval && m == gcd_pkg::ModeUnknown) begin
            if (g) res = gcd_pkg::ModeGround;
            else if (a) res = gcd_pkg::ModeFlying;
        end else if (j.need_eval && m != gcd_pkg::ModeOff) begin
            if (j.item.imu_valid && p && c[15:0] >= f)
                res = (m == gcd_pkg::ModeGround) ? gcd_pkg::ModeFlying : gcd_pkg::ModeGround;
        end
        return res;
    endfunction

    function automatic logic [15:0] n_ticks_out(input logic [1:0] m, input gcd_pkg::t_job j,
            input logic g, input logic a, input logic p, input logic [16:0] c,
            input logic [15:0] f, input logic [15:0] t);
        logic [15:0] res;
        res = t;
        if (j.need_eval && m == gcd_pkg::ModeUnknown) begin
            if (g || a) res = 16'd0;
        end else if (j.need_eval && m != gcd_pkg::ModeOff) begin
            if (j.item.imu_valid && p) res = (c[15:0] >= f) ? 16'd0 : c[15:0];
            else res = 16'd0;
        end
        return res;
    endfunction

    assign it = i_job.item;
    assign o_mode = r_mode;
    assign s_out.valid = r_ov;
    assign s_out.data = r_out;

    // one shared multiplier; operand select per step
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_step)
            5'd0: begin ma = 44'(signed'({1'b0, i_mass})); mb = 26'(it.accel_x); end
            5'd1: begin ma = 44'(signed'({1'b0, i_mass})); mb = 26'(it.accel_y); end
            5'd2: begin ma = 44'(signed'({1'b0, i_mass})); mb = 26'(it.accel_z); end
            5'd3: begin ma = 44'(it.quat_w); mb = 26'(it.quat_w); end
            5'd4: begin ma = 44'(it.quat_x); mb = 26'(it.quat_x); end
            5'd5: begin ma = 44'(it.quat_y); mb = 26'(it.quat_y); end
            5'd6: begin ma = 44'(it.quat_z); mb = 26'(it.quat_z); end
            5'd7: begin ma = 44'(it.quat_x); mb = r_v0; end
            5'd8: begin ma = 44'(it.quat_y); mb = r_v1; end
            5'd9: begin ma = 44'(it.quat_z); mb = r_v2; end
            5'd10: begin ma = 44'(it.quat_y); mb = r_v2; end
            5'd11: begin ma = 44'(it.quat_z); mb = r_v1; end
            5'd12: begin ma = 44'(it.quat_z); mb = r_v0; end
            5'd13: begin ma = 44'(it.quat_x); mb = r_v2; end
            5'd14: begin ma = 44'(it.quat_x); mb = r_v1; end
            5'd15: begin ma = 44'(it.quat_y); mb = r_v0; end
            5'd16: begin ma = 44'(r_s); mb = r_v0; end
            5'd17: begin ma = 44'(r_s); mb = r_v1; end
            5'd18: begin ma = 44'(r_s); mb = r_v2; end
            5'd19: begin ma = r_d; mb = 26'(it.quat_x); end
            5'd20: begin ma = r_d; mb = 26'(it.quat_y); end
            5'd21: begin ma = r_d; mb = 26'(it.quat_z); end
            5'd22: begin ma = r_c0; mb = 26'(it.quat_w); end
            5'd23: begin ma = r_c1; mb = 26'(it.quat_w); end
            5'd24: begin ma = r_c2; mb = 26'(it.quat_w); end
            5'd25: begin
                ma = 44'(signed'({1'b0, i_mass}));
                mb = 26'(signed'({1'b0, gcd_pkg::GravityQ8}));
            end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    assign mp_full = ma * mb;

    // comparisons
    always_comb begin
        ax = (r_r0 >>> 28) < 0 ? -(65'(r_r0 >>> 28)) : 65'(r_r0 >>> 28);
        ay = (r_r1 >>> 28) < 0 ? -(65'(r_r1 >>> 28)) : 65'(r_r1 >>> 28);
        az = (r_r2 >>> 28) < 0 ? -(65'(r_r2 >>> 28)) : 65'(r_r2 >>> 28);
        gq = 65'(r_r2 >>> 28) - 65'(r_g);
        azg = gq < 0 ? -gq : gq;
        pass_x = ax < 65'(signed'({1'b0, i_thr_x}));
        pass_y = ay < 65'(signed'({1'b0, i_thr_y}));
        pass_za = az < 65'(signed'({1'b0, i_thr_z}));
        pass_zg = azg < 65'(signed'({1'b0, i_thr_z}));
        gnd = pass_x && pass_y && pass_zg;
        air = pass_x && pass_y && pass_za;
        pass = (r_mode == gcd_pkg::ModeGround) ? air : gnd;
        inc = {1'b0, r_ticks} + 17'd1;
    end

    always_comb begin
        n_state = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            gcd_pkg::t_st_idle: if (i_job_valid && !r_ov) begin
                if (i_job.need_eval && r_mode != gcd_pkg::ModeOff) n_state = gcd_pkg::t_st_calc;
                else n_state = gcd_pkg::t_st_out;
            end
            gcd_pkg::t_st_calc: if (r_step == 5'd26) n_state = gcd_pkg::t_st_out;
            gcd_pkg::t_st_out: begin
                n_state = gcd_pkg::t_st_idle;
                o_job_pop = 1'b1;
            end
            default: n_state = gcd_pkg::t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcd_pkg::t_st_idle;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mp_full[55:0];
        if (r_state == gcd_pkg::t_st_calc) begin
            r_step <= r_step + 5'd1;
            case (r_step)
                5'd1: r_v0 <= 26'(r_prod >>> 8) - 26'(it.cmd_force_x);
                5'd2: r_v1 <= 26'(r_prod >>> 8) - 26'(it.cmd_force_y);
                5'd3: r_v2 <= 26'(r_prod >>> 8) - 26'(it.cmd_force_z);
                5'd4: r_s <= 35'(r_prod);
                5'd5: r_s <= r_s - 35'(r_prod);
                5'd6: r_s <= r_s - 35'(r_prod);
                5'd7: r_s <= r_s - 35'(r_prod);
                5'd8: r_d <= 44'(r_prod);
                5'd9: r_d <= r_d + 44'(r_prod);
                5'd10: r_d <= r_d + 44'(r_prod);
                5'd11: r_c0 <= 44'(r_prod);
                5'd12: r_c0 <= r_c0 - 44'(r_prod);
                5'd13: r_c1 <= 44'(r_prod);
                5'd14: r_c1 <= r_c1 - 44'(r_prod);
                5'd15: r_c2 <= 44'(r_prod);
                5'd16: r_c2 <= r_c2 - 44'(r_prod);
                5'd17: r_r0 <= 64'(r_prod);
                5'd18: r_r1 <= 64'(r_prod);
                5'd19: r_r2 <= 64'(r_prod);
                5'd20: r_r0 <= r_r0 + (64'(r_prod) <<< 1);
                5'd21: r_r1 <= r_r1 + (64'(r_prod) <<< 1);
                5'd22: r_r2 <= r_r2 + (64'(r_prod) <<< 1);
                5'd23: r_r0 <= r_r0 + (64'(r_prod) <<< 1);
                5'd24: r_r1 <= r_r1 + (64'(r_prod) <<< 1);
                5'd25: r_r2 <= r_r2 + (64'(r_prod) <<< 1);
                5'd26: r_g <= 28'(r_prod >>> 8);
                default: ;
            endcase
        end else begin
            r_step <= 5'd0;
        end
        if (r_state == gcd_pkg::t_st_out) begin
            r_out.contact_state <= n_mode_out(r_mode, i_job, gnd, air, pass, inc, i_filt);
            r_out.debounce_count <= n_ticks_out(r_mode, i_job, gnd, air, pass, inc, i_filt,
                                                r_ticks);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= gcd_pkg::ModeOff;
            r_ticks <= 16'd0;
            r_ov <= 1'b0;
        end else begin
            if (r_state == gcd_pkg::t_st_out) begin
                r_mode <= n_mode_out(r_mode, i_job, gnd, air, pass, inc, i_filt);
                r_ticks <= n_ticks_out(r_mode, i_job, gnd, air, pass, inc, i_filt, r_ticks);
                r_ov <= 1'b1;
            end else if (s_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule

>>> design/ground_contact_detector_unit.sv
// top level: config registers, front queue and back-end engine
// depends on gcd_pkg, gcd_stream_if, gcd_front, gcd_back, assert_macros.svh
//
// channel  | dir | payload
// s_in     | in  | t_in_item (action, quaternion, accel, commanded force, imu_valid)
// s_out    | out | t_out_item (contact_state, debounce_count)
//
// a tick in on-ground, flying or unknown runs 27 steps on one shared multiplier,
// then the output state registers the result and holds it valid until it is taken
// start, stop, off-mode ticks go from idle straight to the output state, with no steps
// the back end starts the next item only after the result transfer out
// the front queue holds two items while the back end works or the output stalls
// reset is synchronous; config loads defaults and the mode goes to off
`include "assert_macros.svh"
module ground_contact_detector_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    gcd_stream_if.sink s_in,
    gcd_stream_if.source s_out,
    input  logic i_cfg_we,
    input  logic [gcd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [gcd_pkg::CfgDataW-1:0] i_cfg_data
);
    logic [15:0] r_mass, r_filt;
    logic [22:0] r_thr_x, r_thr_y, r_thr_z;
    gcd_pkg::t_job job;
    logic job_valid, job_pop;
    logic [1:0] mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= 16'd256;
            r_thr_x <= 23'd256;
            r_thr_y <= 23'd256;
            r_thr_z <= 23'd256;
            r_filt <= 16'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcd_pkg::CfgMass: r_mass <= i_cfg_data[15:0];
                gcd_pkg::CfgThrX: r_thr_x <= i_cfg_data;
                gcd_pkg::CfgThrY: r_thr_y <= i_cfg_data;
                gcd_pkg::CfgThrZ: r_thr_z <= i_cfg_data;
                gcd_pkg::CfgFilt: r_filt <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    gcd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in),
        .o_job(job), .o_job_valid(job_valid), .i_job_pop(job_pop)
    );

    gcd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(job), .i_job_valid(job_valid),
        .o_job_pop(job_pop), .i_mass(r_mass), .i_thr_x(r_thr_x), .i_thr_y(r_thr_y),
        .i_thr_z(r_thr_z), .i_filt(r_filt), .s_out(s_out), .o_mode(mode)
    );

    `GCD_ASSERT_IMPL(a_pop_valid, i_clk, i_rst_n, job_pop |-> job_valid, "pop of empty queue")
    `GCD_ASSERT_IMPL(a_off_zero, i_clk, i_rst_n, (job_pop && job.action == gcd_pkg::ActStop) |=> (mode == gcd_pkg::ModeOff), "stop did not enter off")
    `GCD_ASSERT_NEVER(a_out_reflects, i_clk, i_rst_n, s_out.valid && s_out.data.contact_state != mode, "output disagrees with mode")
endmodule
